// ----- rtl/core/tile_background_pixel_renderer_unit_macros.svh -----
// Assertion macros for the tile background pixel renderer checker.
// Clocked on clk; the gated form is muted while rst_n is low.
`ifndef TILE_BACKGROUND_PIXEL_RENDERER_UNIT_MACROS_SVH
`define TILE_BACKGROUND_PIXEL_RENDERER_UNIT_MACROS_SVH

// check a property outside reset
`define TBPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define TBPR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tbpr_pkg.sv -----
// Shared types, constants and the master colour table of the tile renderer.
// No dependencies.
`timescale 1ns / 1ps

package tbpr_pkg;

  localparam int TBPR_QDEPTH   = 4;
  localparam int TBPR_PAT_DEPTH = 4096;
  localparam int TBPR_MAP_DEPTH = 1024;
  localparam int TBPR_PAL_DEPTH = 32;
  localparam int TBPR_IN_W     = 40;
  localparam int TBPR_OUT_W    = 32;

  localparam logic [9:0] TBPR_ATTR_HI = 10'h3C0;
  localparam logic [7:0] TBPR_MAP_RST = 8'hFF;
  localparam logic [7:0] TBPR_PAL_RST = 8'h0F;

  typedef enum logic [1:0] {
    KIND_RENDER,
    KIND_WR_PAT,
    KIND_WR_MAP,
    KIND_WR_PAL
  } tbpr_kind_t;

  typedef struct packed {
    tbpr_kind_t  kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  px;
    logic [7:0]  py;
  } tbpr_item_t;

  typedef struct packed {
    logic clearing;
  } tbpr_stat_t;

  // {red, green, blue}
  function automatic logic [23:0] tbpr_rgb(input logic [5:0] idx);
    logic [23:0] c;
    case (idx)
      6'd0:  c = 24'h545454;
      6'd1:  c = 24'h001E74;
      6'd2:  c = 24'h081090;
      6'd3:  c = 24'h300088;
      6'd4:  c = 24'h440064;
      6'd5:  c = 24'h5C0030;
      6'd6:  c = 24'h540400;
      6'd7:  c = 24'h3C1800;
      6'd8:  c = 24'h202A00;
      6'd9:  c = 24'h083A00;
      6'd10: c = 24'h004000;
      6'd11: c = 24'h003C00;
      6'd12: c = 24'h00323C;
      6'd16: c = 24'h989698;
      6'd17: c = 24'h084CC4;
      6'd18: c = 24'h3032EC;
      6'd19: c = 24'h5C1EE4;
      6'd20: c = 24'h8814B0;
      6'd21: c = 24'hA01464;
      6'd22: c = 24'h982220;
      6'd23: c = 24'h783C00;
      6'd24: c = 24'h545A00;
      6'd25: c = 24'h287200;
      6'd26: c = 24'h087C00;
      6'd27: c = 24'h007628;
      6'd28: c = 24'h006678;
      6'd32: c = 24'hECEEEC;
      6'd33: c = 24'h4C9AEC;
      6'd34: c = 24'h787CEC;
      6'd35: c = 24'hB062EC;
      6'd36: c = 24'hE454EC;
      6'd37: c = 24'hEC58B4;
      6'd38: c = 24'hEC6A64;
      6'd39: c = 24'hD48820;
      6'd40: c = 24'hA0AA00;
      6'd41: c = 24'h74C400;
      6'd42: c = 24'h4CD020;
      6'd43: c = 24'h38CC6C;
      6'd44: c = 24'h38B4CC;
      6'd45: c = 24'h3C3C3C;
      6'd48: c = 24'hECEEEC;
      6'd49: c = 24'hA8CCEC;
      6'd50: c = 24'hBCBCEC;
      6'd51: c = 24'hD4B2EC;
      6'd52: c = 24'hECAEEC;
      6'd53: c = 24'hECAED4;
      6'd54: c = 24'hECB4B0;
      6'd55: c = 24'hE4C490;
      6'd56: c = 24'hCCD278;
      6'd57: c = 24'hB4DE78;
      6'd58: c = 24'hA8E290;
      6'd59: c = 24'h98E2B4;
      6'd60: c = 24'hA0D6E4;
      6'd61: c = 24'hA0A2A0;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/tbpr_front.sv -----
// Front end: takes input beats, decodes the video address range and builds queue items.
// Depends on tbpr_pkg.
`timescale 1ns / 1ps

module tbpr_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tbpr_pkg::TBPR_IN_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            q_full,
  input  tbpr_pkg::tbpr_stat_t            stat,
  output logic                            push,
  output tbpr_pkg::tbpr_item_t            item
);
  import tbpr_pkg::*;

  logic [13:0] addr;
  logic        keep;

  assign addr = in_tdata[13:0];

  always_comb begin
    item.addr = addr[11:0];
    item.data = in_tdata[21:14];
    item.px   = in_tdata[29:22];
    item.py   = in_tdata[37:30];
    item.kind = KIND_RENDER;
    keep      = 1'b1;
    if (!in_tuser) begin
      if (addr[13:12] == 2'b00) begin
        item.kind = KIND_WR_PAT;
      end else if (addr[13:10] == 4'b1000) begin
        item.kind = KIND_WR_MAP;
      end else if (addr[13:5] == 9'h1F8) begin
        item.kind = KIND_WR_PAL;
      end else begin
        keep = 1'b0;
      end
    end
  end

  assign in_tready = !q_full && !stat.clearing;
  // drop writes outside the mapped ranges
  assign push      = in_tvalid && in_tready && keep;

endmodule

// ----- rtl/core/tbpr_queue.sv -----
// Short item queue between the front end and the render pipeline.
// Depends on tbpr_pkg.
`timescale 1ns / 1ps

module tbpr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tbpr_pkg::tbpr_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_vld,
  output tbpr_pkg::tbpr_item_t head_item
);
  import tbpr_pkg::*;

  localparam int PW = $clog2(TBPR_QDEPTH);

  tbpr_item_t    mem_r [TBPR_QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == PW'(0) + (PW+1)'(TBPR_QDEPTH));
  assign head_vld  = (cnt_r != '0);
  assign head_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

endmodule

// ----- rtl/core/tbpr_back.sv -----
// Render pipeline: tile map, pattern store and palette stages, colour lookup, output register.
// Each store is written in the stage that reads it, so item order holds. Depends on tbpr_pkg.
`timescale 1ns / 1ps

module tbpr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_vld,
  input  tbpr_pkg::tbpr_item_t            head_item,
  output logic                            pop,
  output tbpr_pkg::tbpr_stat_t            stat,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tbpr_pkg::TBPR_OUT_W-1:0] out_tdata
);
  import tbpr_pkg::*;

  localparam int MAW = $clog2(TBPR_MAP_DEPTH);
  localparam int PAW = $clog2(TBPR_PAT_DEPTH);
  localparam int LAW = $clog2(TBPR_PAL_DEPTH);

  logic adv;

  // clear pass over the tile map
  logic           clearing_r;
  logic [MAW-1:0] clr_cnt_r;

  // tile map stage
  logic [7:0]     map_mem [TBPR_MAP_DEPTH];
  logic           map_we;
  logic [MAW-1:0] map_wa, map_ra0, map_ra1;
  logic [7:0]     map_wd, tile_r, attr_r;
  logic           s1_vld_r;
  tbpr_item_t     s1_r;

  // pattern stage
  logic [7:0]     pat_mem [TBPR_PAT_DEPTH];
  logic [PAW-1:0] pat_ra0, pat_ra1;
  logic [7:0]     lo_r, hi_r;
  logic [1:0]     pal_num;
  logic           s2_vld_r;
  tbpr_item_t     s2_r;
  logic [1:0]     s2_pal_r;

  // palette stage
  logic [7:0]     pal_r [TBPR_PAL_DEPTH];
  logic [2:0]     bsel;
  logic [1:0]     value;
  logic [LAW-1:0] pal_idx;
  logic           s3_vld_r;
  logic [5:0]     cidx_r;
  logic [23:0]    rgb;

  logic           out_vld_r;
  logic [TBPR_OUT_W-1:0] out_data_r;

  assign adv           = !out_vld_r || out_tready;
  assign pop           = adv && head_vld;
  assign stat.clearing = clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + MAW'(1);
      if (clr_cnt_r == MAW'(TBPR_MAP_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_comb begin
    map_ra0 = {head_item.py[7:3], head_item.px[7:3]};
    map_ra1 = TBPR_ATTR_HI | MAW'({head_item.py[7:5], head_item.px[7:5]});
    map_we  = clearing_r || (pop && head_item.kind == KIND_WR_MAP);
    map_wa  = clearing_r ? clr_cnt_r : head_item.addr[MAW-1:0];
    map_wd  = clearing_r ? TBPR_MAP_RST : head_item.data;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    if (adv) begin
      tile_r <= map_mem[map_ra0];
      attr_r <= map_mem[map_ra1];
      s1_r   <= head_item;
    end
  end

  always_comb begin
    pat_ra0 = {tile_r, 1'b0, s1_r.py[2:0]};
    pat_ra1 = {tile_r, 1'b1, s1_r.py[2:0]};
    case ({s1_r.py[4], s1_r.px[4]})
      2'b00:   pal_num = attr_r[1:0];
      2'b01:   pal_num = attr_r[3:2];
      2'b10:   pal_num = attr_r[5:4];
      2'b11:   pal_num = attr_r[7:6];
      default: pal_num = attr_r[1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r && s1_r.kind == KIND_WR_PAT) begin
      pat_mem[s1_r.addr[PAW-1:0]] <= s1_r.data;
    end
    if (adv) begin
      lo_r     <= pat_mem[pat_ra0];
      hi_r     <= pat_mem[pat_ra1];
      s2_r     <= s1_r;
      s2_pal_r <= pal_num;
    end
  end

  always_comb begin
    bsel    = ~s2_r.px[2:0];
    value   = {hi_r[bsel], lo_r[bsel]};
    pal_idx = (value == 2'b00) ? '0 : {1'b0, s2_pal_r, value};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TBPR_PAL_DEPTH; i++) begin
        pal_r[i] <= TBPR_PAL_RST;
      end
    end else if (adv && s2_vld_r && s2_r.kind == KIND_WR_PAL) begin
      pal_r[s2_r.addr[LAW-1:0]] <= s2_r.data;
    end
  end

  assign rgb = tbpr_rgb(cidx_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      cidx_r     <= pal_r[pal_idx][5:0];
      out_data_r <= {2'b00, cidx_r, rgb[7:0], rgb[15:8], rgb[23:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= head_vld;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r && s2_r.kind == KIND_RENDER;
      out_vld_r <= s3_vld_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/core/tile_background_pixel_renderer_unit.sv -----
// Top level of the tile background pixel renderer.
// Depends on tbpr_pkg, tbpr_front, tbpr_queue and tbpr_back.
`timescale 1ns / 1ps
//
// Input channel in_*: one beat per item. in_tuser is the operation: low writes
// in_tdata's data byte at its video address (pattern store, tile map or palette),
// high renders the pixel at pixel_x, pixel_y. Writes outside the mapped ranges
// are dropped. Writes give no output beat.
// Output channel out_*: one beat per render item, carrying red, green, blue and
// the six-bit master colour number, in input order.
// A render beat passes through the queue, the tile map, pattern and palette stage
// registers and the output register before it shows on out_tvalid. Throughput:
// one item per clock while the output is not stalled, and the render pipeline
// then moves one stage per cycle; the tile map and pattern store each read two bytes.
// Reset: the palette returns to 0x0F at once; the tile map is filled with 0xFF
// by a clear pass over all 1024 entries, during which in_tready stays low.
// Stall: when out_tready is low with an output beat pending, the pipeline holds, and a
// four-entry queue keeps taking input beats until it fills; in_tready then drops.
//
module tile_background_pixel_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // address[13:0], data[21:14], pixel_x[29:22], pixel_y[37:30]
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // red[7:0], green[15:8], blue[23:16], color_index[29:24]
);
  import tbpr_pkg::*;

  logic       push, q_full, pop, head_vld;
  tbpr_item_t push_item, head_item;
  tbpr_stat_t stat;

  tbpr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .stat      (stat),
    .push      (push),
    .item      (push_item)
  );

  tbpr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_vld  (head_vld),
    .head_item (head_item)
  );

  tbpr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head_item  (head_item),
    .pop        (pop),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- rtl/core/tbpr_checker.sv -----
// Port-level checker for the tile background pixel renderer, bound to the top level.
// Depends on tile_background_pixel_renderer_unit_macros.svh.
`timescale 1ns / 1ps
`include "tile_background_pixel_renderer_unit_macros.svh"

module tbpr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  `TBPR_ASSERT_RST(a_rst_in_block, !rst_n |=> !in_tready, "input ready right after reset")
  `TBPR_ASSERT_RST(a_rst_out_idle, !rst_n |=> !out_tvalid, "output beat right after reset")
  `TBPR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output beat changed")
  `TBPR_ASSERT(a_black_entry, out_tvalid && (out_tdata[29:24] == 6'd13) |-> (out_tdata[23:0] == 24'd0), "colour 13 not black")
  `TBPR_ASSERT(a_pad_zero, out_tvalid |-> (out_tdata[31:30] == 2'b00), "output padding not zero")

endmodule

bind tile_background_pixel_renderer_unit tbpr_checker u_tbpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
